// ===== rtl/rau_pkg.sv =====
// shared types and constants for the rational arithmetic unit
package rau_pkg;

  localparam int unsigned WideBits = 64;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  typedef struct packed {
    logic                start;
    logic [WideBits-1:0] dividend;
    logic [WideBits-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [WideBits-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/rational_arith_unit.sv =====
// rational add/sub/mul/div with gcd reduction, top level and sequencer
//
// channel | direction | handshake              | words
// input   | in        | in_valid_i / in_stall_o  | operation, a_num, a_den, b_num, b_den
// output  | out       | out_valid_o / out_stall_i| result_num, result_den, status
//
// one word runs the cross products, the binary gcd steps and two serial divides in turn
// the 64-bit compare/subtract of the gcd loop and the serial divider set how long a word takes
// zero denominators and divide by zero go straight to the finish state, zero results skip the gcd and divides
// reset clears the sequencer and the output valid; no clearing pass
// a new word is taken while a finished result waits for out_stall_i to drop
module rational_arith_unit #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic signed [31:0] a_num_i,
  input  logic [30:0]        a_den_i,
  input  logic signed [31:0] b_num_i,
  input  logic [30:0]        b_den_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] result_num_o,
  output logic [30:0]        result_den_o,
  output logic [1:0]         status_o
);

  localparam int unsigned W = rau_pkg::WideBits;
  localparam logic [W-1:0] Limit = (W'(1) << (WORD_BITS - 1)) - W'(1);

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_M1   = 12'b0000_0000_0010,
    S_M2   = 12'b0000_0000_0100,
    S_M3   = 12'b0000_0000_1000,
    S_M4   = 12'b0000_0001_0000,
    S_GTWO = 12'b0000_0010_0000,
    S_GRUN = 12'b0000_0100_0000,
    S_D1S  = 12'b0000_1000_0000,
    S_D1W  = 12'b0001_0000_0000,
    S_D2S  = 12'b0010_0000_0000,
    S_D2W  = 12'b0100_0000_0000,
    S_FIN  = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [1:0]         op_q;
  logic signed [31:0] an_q, bn_q;
  logic [30:0]        ad_q, bd_q;
  logic [W-1:0]       num_q, num_d, den_q, den_d, mag_q, mag_d;
  logic [W-1:0]       x_q, x_d, y_q, y_d, g_q, g_d;
  logic [5:0]         k_q, k_d;
  logic               neg_q, neg_d;
  logic [31:0]        rnum_q, rnum_d;
  logic [30:0]        rden_q, rden_d;
  logic [1:0]         rst_q, rst_d;
  logic               ovalid_q, ovalid_d;

  logic signed [32:0] mul_a, mul_b, bn_abs;
  logic [W-1:0]       prod;
  rau_pkg::div_req_t  div_req;
  rau_pkg::div_rsp_t  div_rsp;
  logic               accept, out_free;
  logic [W-1:0]       xy_diff, yx_diff;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !ovalid_q || !out_stall_i;
  assign bn_abs   = bn_q[31] ? -33'(bn_q) : 33'(bn_q);
  assign xy_diff  = x_q - y_q;
  assign yx_diff  = y_q - x_q;

  always_comb begin
    mul_a = 33'(an_q);
    mul_b = $signed({2'b00, bd_q});
    case (state_q)
      S_M1: begin
        mul_a = 33'(an_q);
        mul_b = (op_q == rau_pkg::OP_MUL) ? 33'(bn_q) : $signed({2'b00, bd_q});
      end
      S_M2: begin
        mul_a = 33'(bn_q);
        mul_b = $signed({2'b00, ad_q});
      end
      S_M3: begin
        mul_a = $signed({2'b00, ad_q});
        mul_b = (op_q == rau_pkg::OP_DIV) ? bn_abs : $signed({2'b00, bd_q});
      end
      default: ;
    endcase
  end

  rau_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  always_comb begin
    div_req.start    = (state_q == S_D1S) || (state_q == S_D2S);
    div_req.dividend = (state_q == S_D2S) ? den_q : mag_q;
    div_req.divisor  = g_q;
  end

  rau_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d  = state_q;
    num_d    = num_q;
    den_d    = den_q;
    mag_d    = mag_q;
    x_d      = x_q;
    y_d      = y_q;
    g_d      = g_q;
    k_d      = k_q;
    neg_d    = neg_q;
    rnum_d   = rnum_q;
    rden_d   = rden_q;
    rst_d    = rst_q;
    ovalid_d = ovalid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          rnum_d = '0;
          rden_d = 31'd1;
          rst_d  = rau_pkg::ST_DIV0;
          if (a_den_i == '0 || b_den_i == '0 ||
              (operation_i == rau_pkg::OP_DIV && b_num_i == '0)) begin
            state_d = S_FIN;
          end else begin
            state_d = S_M1;
          end
        end
      end
      S_M1: state_d = S_M2;
      S_M2: begin
        num_d   = prod;
        state_d = S_M3;
      end
      S_M3: begin
        if (op_q == rau_pkg::OP_ADD) begin
          num_d = num_q + prod;
        end else if (op_q == rau_pkg::OP_SUB) begin
          num_d = num_q - prod;
        end
        state_d = S_M4;
      end
      S_M4: begin
        den_d = prod;
        neg_d = num_q[W-1] ^ ((op_q == rau_pkg::OP_DIV) && bn_q[31]);
        mag_d = num_q[W-1] ? -num_q : num_q;
        x_d   = num_q[W-1] ? -num_q : num_q;
        y_d   = prod;
        k_d   = '0;
        if (num_q == '0) begin
          rst_d   = rau_pkg::ST_OK;
          state_d = S_FIN;
        end else begin
          state_d = S_GTWO;
        end
      end
      S_GTWO: begin
        // strip common factors of two
        if (!x_q[0] && !y_q[0]) begin
          x_d = x_q >> 1;
          y_d = y_q >> 1;
          k_d = k_q + 1'b1;
        end else begin
          state_d = S_GRUN;
        end
      end
      S_GRUN: begin
        if (x_q == '0) begin
          g_d     = y_q << k_q;
          state_d = S_D1S;
        end else if (y_q == '0) begin
          g_d     = x_q << k_q;
          state_d = S_D1S;
        end else if (!x_q[0]) begin
          x_d = x_q >> 1;
        end else if (!y_q[0]) begin
          y_d = y_q >> 1;
        end else if (x_q >= y_q) begin
          x_d = xy_diff;
        end else begin
          y_d = yx_diff;
        end
      end
      S_D1S: state_d = S_D1W;
      S_D1W: begin
        if (div_rsp.done) begin
          mag_d   = div_rsp.quotient;
          state_d = S_D2S;
        end
      end
      S_D2S: state_d = S_D2W;
      S_D2W: begin
        if (div_rsp.done) begin
          if (mag_q > Limit || div_rsp.quotient > Limit) begin
            rst_d = rau_pkg::ST_OVF;
          end else begin
            rst_d  = rau_pkg::ST_OK;
            rnum_d = neg_q ? -mag_q[31:0] : mag_q[31:0];
            rden_d = div_rsp.quotient[30:0];
          end
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= operation_i;
      an_q <= a_num_i;
      ad_q <= a_den_i;
      bn_q <= b_num_i;
      bd_q <= b_den_i;
    end
    num_q <= num_d;
    den_q <= den_d;
    mag_q <= mag_d;
    x_q   <= x_d;
    y_q   <= y_d;
    g_q   <= g_d;
    k_q   <= k_d;
    neg_q <= neg_d;
    rst_q <= rst_d;
    // result word only changes when loaded from the sequencer
    if (state_q == S_FIN && out_free) begin
      result_num_o <= rnum_q;
      result_den_o <= rden_q;
      status_o     <= rst_q;
    end
    rnum_q <= rnum_d;
    rden_q <= rden_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = ovalid_q;

  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != rau_pkg::ST_OK |-> result_num_o == '0 && result_den_o == 31'd1)
    else $error("error status with nonzero result");

  a_den_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> result_den_o != '0)
    else $error("zero result denominator");

  a_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != S_IDLE)
    else $error("sequencer idle after accepting a word");

  a_gcd_nz : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_D1W |-> g_q != '0)
    else $error("zero gcd");

endmodule

// ===== rtl/rau_mul.sv =====
// registered signed multiplier shared by the cross products
module rau_mul (
  input  logic                               clk_i,
  input  logic signed [32:0]                 a_i,
  input  logic signed [32:0]                 b_i,
  output logic        [rau_pkg::WideBits-1:0] p_o
);

  logic signed [65:0] prod;

  assign prod = a_i * b_i;

  always_ff @(posedge clk_i) begin
    p_o <= prod[rau_pkg::WideBits-1:0];
  end

endmodule

// ===== rtl/rau_div.sv =====
// restoring divider, one quotient bit per cycle
module rau_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rau_pkg::div_req_t req_i,
  output rau_pkg::div_rsp_t rsp_o
);

  localparam int unsigned W = rau_pkg::WideBits;

  logic [W:0]           rem_q, rem_d;
  logic [W-1:0]         quo_q, quo_d;
  logic [W-1:0]         dvs_q;
  logic [$clog2(W+1)-1:0] cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic [W:0]           rem_sh, diff;

  always_comb begin
    rem_sh = {rem_q[W-1:0], quo_q[W-1]};
    diff   = rem_sh - {1'b0, dvs_q};
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d = '0;
      quo_d = req_i.dividend;
      cnt_d = ($clog2(W+1))'(W);
    end else if (cnt_q != '0) begin
      if (!diff[W]) begin
        rem_d = diff;
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      done_d = (cnt_q == ($clog2(W+1))'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (req_i.start) begin
      dvs_q <= req_i.divisor;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule
